### src/prts_pkg.sv
package prts_pkg;

  // Input item fields
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned CH_W       = 3;
  localparam int unsigned BUF_W      = 2;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned IN_TDATA_W = 24;
  localparam int unsigned IN_BUF_LSB = CH_W;
  localparam int unsigned IN_VAL_LSB = CH_W + BUF_W;
  localparam int unsigned IN_PND_BIT = CH_W + BUF_W + VAL_W;

  // Result item fields
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration registers
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned RELOAD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD    = 1'd1;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 8'd1;
  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK      = 3'd0,
    REQ_ARM_TX    = 3'd1,
    REQ_CLR_TX    = 3'd2,
    REQ_ARM_RX    = 3'd3,
    REQ_SET_START = 3'd4
  } req_type_e;

  typedef enum logic [KIND_W-1:0] {
    EV_ACK        = 2'd0,
    EV_RETX       = 2'd1,
    EV_RX_TIMEOUT = 2'd2,
    EV_TICK_DONE  = 2'd3
  } event_kind_e;

endpackage

### src/prts_tmem.sv
module prts_tmem
  import prts_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned DW    = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0] rdata_q;
  logic          rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Entries never written since reset read as zero (timer inactive)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

### src/packet_retransmit_timer_scan_unit.sv
// Control items (arm, clear, set start, arm receive): one acknowledge, offered from the
// acknowledge state once the result slot is free; the next item can be taken after that.
// Tick: receive step, one timer memory entry per cycle, finish step. The retry cap ends the
// walk early; a result waiting on a stalled output holds the walk until it leaves.
// Reset clears control state and loads the configuration reset values; timers read as zero
// via per-entry valid bits.
module packet_retransmit_timer_scan_unit
  import prts_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS     = 8,
  parameter int unsigned BUFS_PER_CHANNEL = 4,
  parameter int unsigned MAX_RETRIES      = 4,
  parameter int unsigned TIMER_WIDTH      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] channel, [4:3] buffer, [20:5] timer_value, [21] input_pending, [23:22] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [REQ_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [2:0] event_channel, [4:3] event_buffer, [5] timers_active, [7:6] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] event_kind
  output logic [KIND_W-1:0]      m_axis_tuser,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NUM_ENTRIES = NUM_CHANNELS * BUFS_PER_CHANNEL;
  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned BW = $clog2(BUFS_PER_CHANNEL);
  localparam int unsigned RW = $clog2(MAX_RETRIES + 1);
  localparam int unsigned TW = TIMER_WIDTH;
  localparam logic [BW-1:0] LAST_BUF = BW'(BUFS_PER_CHANNEL - 1);
  localparam logic [CW-1:0] LAST_CH  = CW'(NUM_CHANNELS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_RECV,
    ST_SCAN,
    ST_FIN
  } state_e;

  function automatic logic [BW-1:0] norm_start(input logic [BUF_W-1:0] s);
    logic [31:0] e;
    e = 32'(s);
    return (e < BUFS_PER_CHANNEL) ? BW'(e) : '0;
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic [31:0] c, input logic [31:0] b);
    logic [31:0] a;
    a = c * BUFS_PER_CHANNEL + b;
    return a[AW-1:0];
  endfunction

  function automatic logic [TW-1:0] lower(input logic [TW-1:0] t, input logic [TW-1:0] r);
    return (t <= r) ? '0 : (t - r);
  endfunction

  state_e state_q;

  logic [RATE_W-1:0]   rate_q;
  logic [RELOAD_W-1:0] reload_q;
  logic [TW-1:0]       rx_q;
  logic                pend_q;
  logic [BUF_W-1:0]    start_q [NUM_CHANNELS];

  logic [CW-1:0] iss_ch_q;
  logic [BW-1:0] iss_cnt_q;
  logic [BW-1:0] iss_idx_q;
  logic          iss_done_q;
  logic          prc_v_q;
  logic [CW-1:0] prc_ch_q;
  logic [BW-1:0] prc_idx_q;
  logic [RW-1:0] retries_q;
  logic          active_q;

  logic                m_valid_q;
  logic [KIND_W-1:0]   m_kind_q;
  logic [CH_W-1:0]     m_ch_q;
  logic [BUF_W-1:0]    m_buf_q;
  logic                m_act_q;
  logic                m_last_q;

  // Input fields
  logic [REQ_W-1:0] in_req;
  logic [CH_W-1:0]  in_ch;
  logic [BUF_W-1:0] in_buf;
  logic [VAL_W-1:0] in_val;
  logic             in_pend;
  logic             in_ok;
  logic             accept;
  logic [CW-1:0]    in_ch_idx;

  logic          slot_free;
  logic [TW-1:0] rate_tw;
  logic [TW-1:0] reload_tw;
  logic [TW-1:0] rx_low;
  logic          rx_emit;
  logic          recv_go;

  logic [TW-1:0] t_cur;
  logic [TW-1:0] t_low;
  logic          prc_live;
  logic          prc_expire;
  logic          cap_hit;
  logic          scan_stall;
  logic          issue;

  logic          iss_last_in_ch;
  logic [CW-1:0] nxt_ch;
  logic [BW-1:0] nxt_idx;
  logic [BW-1:0] nxt_cnt;
  logic          nxt_done;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] mem_rdata;

  assign in_req    = s_axis_tuser;
  assign in_ch     = s_axis_tdata[CH_W-1:0];
  assign in_buf    = s_axis_tdata[IN_BUF_LSB +: BUF_W];
  assign in_val    = s_axis_tdata[IN_VAL_LSB +: VAL_W];
  assign in_pend   = s_axis_tdata[IN_PND_BIT];
  assign in_ok     = (32'(in_ch) < NUM_CHANNELS) && (32'(in_buf) < BUFS_PER_CHANNEL);
  assign in_ch_idx = CW'(in_ch);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_valid_q || m_axis_tready;

  assign rate_tw   = TW'(rate_q);
  assign reload_tw = TW'(reload_q);

  // Receive step
  assign rx_low  = lower(rx_q, rate_tw);
  assign rx_emit = (rx_q != '0) && !pend_q && (rx_low == '0);
  assign recv_go = !rx_emit || slot_free;

  // Process stage: entry read at the last issue
  assign t_cur      = mem_rdata;
  assign t_low      = lower(t_cur, rate_tw);
  assign prc_live   = prc_v_q && (t_cur != '0);
  assign prc_expire = prc_live && (t_low == '0);
  assign cap_hit    = prc_expire && ((32'(retries_q) + 32'd1) >= MAX_RETRIES);
  assign scan_stall = prc_expire && !slot_free;

  always_comb begin
    issue = 1'b0;
    unique case (state_q)
      ST_RECV: issue = recv_go;
      ST_SCAN: issue = !scan_stall && !cap_hit && !iss_done_q;
      default: issue = 1'b0;
    endcase
  end

  // Circular walk within a channel, channels in order
  always_comb begin
    iss_last_in_ch = (iss_cnt_q == LAST_BUF);
    nxt_done       = iss_last_in_ch && (iss_ch_q == LAST_CH);
    if (iss_last_in_ch) begin
      nxt_ch  = nxt_done ? '0 : (iss_ch_q + CW'(1));
      nxt_cnt = '0;
      nxt_idx = norm_start(start_q[nxt_ch]);
    end else begin
      nxt_ch  = iss_ch_q;
      nxt_cnt = iss_cnt_q + BW'(1);
      nxt_idx = (iss_idx_q == LAST_BUF) ? '0 : (iss_idx_q + BW'(1));
    end
  end

  assign mem_raddr = entry_addr(32'(iss_ch_q), 32'(iss_idx_q));

  // Reads and writes of one tick never touch the same entry in one cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = entry_addr(32'(prc_ch_q), 32'(prc_idx_q));
    mem_wdata = prc_expire ? reload_tw : t_low;
    if (state_q == ST_IDLE) begin
      mem_waddr = entry_addr(32'(in_ch), 32'(in_buf));
      mem_wdata = (in_req == REQ_ARM_TX) ? TW'(in_val) : '0;
      mem_we    = accept && in_ok && ((in_req == REQ_ARM_TX) || (in_req == REQ_CLR_TX));
    end else if (state_q == ST_SCAN) begin
      mem_we = prc_live && !scan_stall;
    end
  end

  prts_tmem #(
    .DEPTH (NUM_ENTRIES),
    .DW    (TW)
  ) u_tmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (issue),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rate_q     <= RATE_RESET;
      reload_q   <= RELOAD_RESET;
      rx_q       <= '0;
      pend_q     <= 1'b0;
      start_q    <= '{default: '0};
      iss_ch_q   <= '0;
      iss_cnt_q  <= '0;
      iss_idx_q  <= '0;
      iss_done_q <= 1'b0;
      prc_v_q    <= 1'b0;
      prc_ch_q   <= '0;
      prc_idx_q  <= '0;
      retries_q  <= '0;
      active_q   <= 1'b0;
      m_valid_q  <= 1'b0;
      m_kind_q   <= EV_ACK;
      m_ch_q     <= '0;
      m_buf_q    <= '0;
      m_act_q    <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SCAN_RATE: rate_q   <= cfg_data_i[RATE_W-1:0];
          REG_RELOAD:    reload_q <= cfg_data_i[RELOAD_W-1:0];
          default:       ;
        endcase
      end

      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      if (issue) begin
        iss_ch_q   <= nxt_ch;
        iss_cnt_q  <= nxt_cnt;
        iss_idx_q  <= nxt_idx;
        iss_done_q <= nxt_done;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_req == REQ_TICK) begin
              pend_q     <= in_pend;
              iss_ch_q   <= '0;
              iss_cnt_q  <= '0;
              iss_idx_q  <= norm_start(start_q[0]);
              iss_done_q <= 1'b0;
              retries_q  <= '0;
              active_q   <= 1'b0;
              state_q    <= ST_RECV;
            end else begin
              if (in_req == REQ_SET_START && in_ok) begin
                start_q[in_ch_idx] <= in_buf;
              end
              if (in_req == REQ_ARM_RX) begin
                rx_q <= TW'(in_val);
              end
              state_q <= ST_ACK;
            end
          end
        end

        ST_ACK: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= EV_ACK;
            m_ch_q    <= '0;
            m_buf_q   <= '0;
            m_act_q   <= 1'b0;
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        ST_RECV: begin
          if (recv_go) begin
            active_q <= (rx_q != '0);
            if (rx_q != '0 && !pend_q) begin
              rx_q <= rx_low;
            end
            if (rx_emit) begin
              m_valid_q <= 1'b1;
              m_kind_q  <= EV_RX_TIMEOUT;
              m_ch_q    <= '0;
              m_buf_q   <= '0;
              m_act_q   <= 1'b0;
              m_last_q  <= 1'b0;
            end
            prc_v_q   <= 1'b1;
            prc_ch_q  <= iss_ch_q;
            prc_idx_q <= iss_idx_q;
            state_q   <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (!scan_stall) begin
            if (prc_live) begin
              active_q <= 1'b1;
            end
            if (prc_expire) begin
              m_valid_q <= 1'b1;
              m_kind_q  <= EV_RETX;
              m_ch_q    <= CH_W'(prc_ch_q);
              m_buf_q   <= BUF_W'(prc_idx_q);
              m_act_q   <= 1'b0;
              m_last_q  <= 1'b0;
              retries_q <= retries_q + RW'(1);
            end
            if (cap_hit || iss_done_q) begin
              prc_v_q <= 1'b0;
              state_q <= ST_FIN;
            end else begin
              prc_v_q   <= 1'b1;
              prc_ch_q  <= iss_ch_q;
              prc_idx_q <= iss_idx_q;
            end
          end
        end

        ST_FIN: begin
          if (slot_free) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= EV_TICK_DONE;
            m_ch_q    <= '0;
            m_buf_q   <= '0;
            m_act_q   <= active_q;
            m_last_q  <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_act_q, m_buf_q, m_ch_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule

### src/prts_checker.sv
module prts_checker
  import prts_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [KIND_W-1:0]      m_axis_tuser,
  input logic                   m_axis_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // One item at a time: busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_ACK || m_axis_tuser == EV_TICK_DONE)
      |-> m_axis_tlast)
    else $error("closing result without tlast");

  a_event_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_RETX || m_axis_tuser == EV_RX_TIMEOUT)
      |-> !m_axis_tlast)
    else $error("tick event marked last");

  a_active_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != EV_TICK_DONE |-> !m_axis_tdata[5])
    else $error("timers_active set outside tick completion");

endmodule

bind packet_retransmit_timer_scan_unit prts_checker u_prts_checker (.*);

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import prts_pkg::*;

  localparam int N_CHAN       = 8;
  localparam int N_SLOT       = 4;
  localparam int RETRY_CAP    = 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 50;
  localparam int MAX_PRINTS   = 50;

  localparam int OUT_SLOT_LSB = CH_W;
  localparam int OUT_ACT_BIT  = CH_W + BUF_W;

  // request codes above the defined set, acknowledged and otherwise ignored
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = REQ_SET_START + 1'b1;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = '1;

  typedef struct packed {
    event_kind_e       kind;
    logic [CH_W-1:0]   chan;
    logic [BUF_W-1:0]  slot;
    logic              active;
    logic              last;
  } timer_event_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [REQ_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]      m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  packet_retransmit_timer_scan_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // timer state as the block should hold it
  logic [VAL_W-1:0]    tx_timer [N_CHAN][N_SLOT];
  logic [BUF_W-1:0]    start_slot [N_CHAN];
  logic [VAL_W-1:0]    rx_timer;
  logic [RATE_W-1:0]   scan_rate_cfg;
  logic [RELOAD_W-1:0] reload_cfg;

  timer_event_t timer_events_due[$];
  int           errors = 0;
  int           cycles = 0;
  bit           no_gaps = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] tick_down(input logic [VAL_W-1:0] t);
    return (t <= VAL_W'(scan_rate_cfg)) ? '0 : t - VAL_W'(scan_rate_cfg);
  endfunction

  function automatic void push_event(input event_kind_e kind, input logic [CH_W-1:0] chan,
                                     input logic [BUF_W-1:0] slot, input logic active,
                                     input logic last);
    timer_event_t ev;
    ev.kind   = kind;
    ev.chan   = chan;
    ev.slot   = slot;
    ev.active = active;
    ev.last   = last;
    timer_events_due.push_back(ev);
  endfunction

  function automatic void apply_item(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] chan,
                                     input logic [BUF_W-1:0] slot,
                                     input logic [VAL_W-1:0] tval, input logic pend);
    logic             any_active;
    int               retx;
    int               c;
    int               i;
    logic [BUF_W-1:0] idx;
    if (req != REQ_TICK) begin
      case (req)
        REQ_ARM_TX:    tx_timer[chan][slot] = tval;
        REQ_CLR_TX:    tx_timer[chan][slot] = '0;
        REQ_ARM_RX:    rx_timer = tval;
        REQ_SET_START: start_slot[chan] = slot;
        default: ;
      endcase
      push_event(EV_ACK, '0, '0, 1'b0, 1'b1);
      return;
    end
    any_active = 1'b0;
    retx = 0;
    if (rx_timer != '0) begin
      any_active = 1'b1;
      if (!pend) begin
        rx_timer = tick_down(rx_timer);
        if (rx_timer == '0) push_event(EV_RX_TIMEOUT, '0, '0, 1'b0, 1'b0);
      end
    end
    // the scan stops dead once the retry cap is hit; unexamined timers do not count
    for (c = 0; c < N_CHAN && retx < RETRY_CAP; c++) begin
      idx = start_slot[c];
      for (i = 0; i < N_SLOT && retx < RETRY_CAP; i++) begin
        if (tx_timer[c][idx] != '0) begin
          any_active = 1'b1;
          tx_timer[c][idx] = tick_down(tx_timer[c][idx]);
          if (tx_timer[c][idx] == '0) begin
            tx_timer[c][idx] = reload_cfg;
            push_event(EV_RETX, CH_W'(c), idx, 1'b0, 1'b0);
            retx++;
          end
        end
        idx = idx + 1'b1;  // four slots, so the index wraps by itself
      end
    end
    push_event(EV_TICK_DONE, '0, '0, any_active, 1'b1);
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic check_event();
    timer_event_t want;
    if (timer_events_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", m_axis_tuser));
      return;
    end
    want = timer_events_due.pop_front();
    if (m_axis_tuser !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
    if (m_axis_tdata[CH_W-1:0] !== want.chan)
      report_mismatch($sformatf("channel %0d, want %0d", m_axis_tdata[CH_W-1:0], want.chan));
    if (m_axis_tdata[OUT_SLOT_LSB +: BUF_W] !== want.slot)
      report_mismatch($sformatf("buffer %0d, want %0d",
                                m_axis_tdata[OUT_SLOT_LSB +: BUF_W], want.slot));
    if (m_axis_tdata[OUT_ACT_BIT] !== want.active)
      report_mismatch($sformatf("timers_active %0b, want %0b",
                                m_axis_tdata[OUT_ACT_BIT], want.active));
    if (m_axis_tlast !== want.last)
      report_mismatch($sformatf("tlast %0b, want %0b", m_axis_tlast, want.last));
  endtask

  // result side: random stall before each item, tready otherwise held high
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_event();
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [CH_W-1:0] chan,
                           input logic [BUF_W-1:0] slot, input logic [VAL_W-1:0] tval,
                           input logic pend);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, pend, tval, slot, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_item(req, chan, slot, tval, pend);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (timer_events_due.size() != 0);
  endtask

  // block idle here: both registers written on back-to-back edges
  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [RELOAD_W-1:0] rl);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SCAN_RATE;
    cfg_data_i <= CFG_DATA_W'(rate);
    @(posedge clk_i);
    cfg_idx_i  <= REG_RELOAD;
    cfg_data_i <= rl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    scan_rate_cfg = rate;
    reload_cfg    = rl;
  endtask

  task automatic test_control_items();
    int r;
    send_item(REQ_ARM_TX, 3'd0, 2'd0, 16'hFFFF, 1'b1);
    send_item(REQ_ARM_TX, 3'd7, 2'd3, 16'd1, 1'b0);
    send_item(REQ_ARM_TX, 3'd3, 2'd1, 16'd0, 1'b0);
    send_item(REQ_SET_START, 3'd7, 2'd3, 16'h0000, 1'b1);
    send_item(REQ_CLR_TX, 3'd0, 2'd0, 16'hFFFF, 1'b0);
    for (r = int'(REQ_SPARE_FIRST); r <= int'(REQ_SPARE_LAST); r++)
      send_item(REQ_W'(r), CH_W'($urandom_range(0, 7)), BUF_W'($urandom_range(0, 3)),
                VAL_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    send_item(REQ_TICK, 3'd7, 2'd3, 16'hFFFF, 1'b0);
  endtask

  task automatic test_receive_timer();
    send_item(REQ_ARM_RX, 3'd2, 2'd1, 16'd2, 1'b1);
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b1);  // pending input freezes it
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b0);
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b0);
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b0);
  endtask

  // five timers due on the same tick; only four retransmits may go out
  task automatic test_retry_cap();
    int s;
    for (s = 0; s < N_SLOT; s++) send_item(REQ_ARM_TX, 3'd1, BUF_W'(s), 16'd1, 1'b0);
    send_item(REQ_ARM_TX, 3'd2, 2'd0, 16'd1, 1'b0);
    send_item(REQ_SET_START, 3'd1, 2'd2, 16'd0, 1'b0);
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b0);
    send_item(REQ_TICK, 3'd0, 2'd0, 16'd0, 1'b0);
  endtask

  task automatic send_random_item();
    int               pick;
    logic [REQ_W-1:0] req;
    logic [VAL_W-1:0] tval;
    pick = $urandom_range(0, 99);
    if (pick < 35)      req = REQ_TICK;
    else if (pick < 68) req = REQ_ARM_TX;
    else if (pick < 78) req = REQ_CLR_TX;
    else if (pick < 87) req = REQ_SET_START;
    else if (pick < 96) req = REQ_ARM_RX;
    else                req = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    tval = VAL_W'($urandom_range(0, 65535));
    // mostly short timeouts so that timers run out within a few ticks
    if ((req == REQ_ARM_TX || req == REQ_ARM_RX) && $urandom_range(0, 99) < 70)
      tval = VAL_W'($urandom_range(0, 4 * scan_rate_cfg));
    send_item(req, CH_W'($urandom_range(0, 7)), BUF_W'($urandom_range(0, 3)), tval,
              $urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_traffic();
    int ph;
    int n;
    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: set_config(8'd255, 16'd1);
        1: set_config(8'd1, 16'hFFFF);
        2: set_config(RATE_W'($urandom_range(1, 255)), RELOAD_W'($urandom_range(1, 8)));
        3: set_config(RATE_W'($urandom_range(1, 16)), RELOAD_W'($urandom_range(1, 65535)));
        default: set_config(RATE_W'($urandom_range(1, 255)),
                            RELOAD_W'($urandom_range(1, 65535)));
      endcase
      no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end
  endtask

  initial begin
    for (int c = 0; c < N_CHAN; c++) begin
      start_slot[c] = '0;
      for (int s = 0; s < N_SLOT; s++) tx_timer[c][s] = '0;
    end
    rx_timer      = '0;
    scan_rate_cfg = RATE_RESET;
    reload_cfg    = RELOAD_RESET;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_control_items();
    test_receive_timer();
    test_retry_cap();
    test_random_traffic();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
